/* src/crc32c_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crc32c_pkg: shared types and constants for the crc-32c stream checksum
// reflected castagnoli polynomial, field layout of the stream words and the
// gf(2) matrix helpers used to build the fixed xor networks
// ---------------------------------------------------------------------------
package crc32c_pkg;

	localparam int          CrcW            = 32;
	localparam int          ByteW           = 8;
	localparam int          DataW           = 64;
	localparam int          DataBytes       = DataW / ByteW;
	localparam int          CountW          = 4;
	localparam int          CmpW            = CountW + 1;
	localparam int          BytesPerItemDef = 8;

	// input word layout, lowest field first
	localparam int          MsgLsb          = 0;
	localparam int          CountLsb        = MsgLsb + DataW;
	localparam int          SeedLsb         = CountLsb + CountW;
	localparam int          InFieldsW       = SeedLsb + CrcW;
	localparam int          InTdataW        = ((InFieldsW + 7) / 8) * 8;
	localparam int          OutTdataW       = CrcW;

	localparam logic [31:0] Poly            = 32'h82F6_3B78;
	localparam logic [7:0]  ByteMask        = 8'hFF;

	typedef logic [CrcW-1:0]            crc_t;
	typedef logic [CrcW-1:0][CrcW-1:0]  crc_mat_t;   // one column per input bit

	// pipeline item handed from the lane stage to the state update
	typedef struct packed {
		crc_t              data_part;   // merged lane contributions
		crc_t              seed;
		logic [CmpW-1:0]   count;       // saturated byte count
		logic              start;
	} item_s1_t;

	// advance a remainder over nbits zero bits (elaboration only)
	function automatic crc_t shift_zero(input crc_t r, input int nbits);
		crc_t acc;
		acc = r;
		for (int i = 0; i < nbits; i++) begin
			acc = acc[0] ? ((acc >> 1) ^ Poly) : (acc >> 1);
		end
		return acc;
	endfunction

	// matrix that advances a remainder over nbytes zero bytes
	function automatic crc_mat_t adv_mat(input int nbytes);
		crc_mat_t m;
		for (int j = 0; j < CrcW; j++) begin
			m[j] = shift_zero(crc_t'(1) << j, ByteW * nbytes);
		end
		return m;
	endfunction

	// gf(2) matrix times vector: xor of the selected columns
	function automatic crc_t mat_mul(input crc_mat_t m, input crc_t v);
		crc_t acc;
		acc = '0;
		for (int j = 0; j < CrcW; j++) begin
			if (v[j]) begin
				acc = acc ^ m[j];
			end
		end
		return acc;
	endfunction

endpackage

/* src/crc32c_lane.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crc32c_lane: contribution of one byte position
// folds one byte from a zero remainder and advances it over the bytes that
// follow it in the same word, picked by the byte count
// ---------------------------------------------------------------------------
module crc32c_lane #(
	parameter int LANE  = 0,
	parameter int BYTES = crc32c_pkg::BytesPerItemDef
) (
	input  logic [crc32c_pkg::ByteW-1:0] lane_byte,
	input  logic [crc32c_pkg::CmpW-1:0]  count,
	output crc32c_pkg::crc_t             contrib
);

	localparam int MaxK = BYTES - LANE;

	crc32c_pkg::crc_t prod [1:MaxK];

	// k = number of bytes from this one to the end of the word
	for (genvar k = 1; k <= MaxK; k++) begin : g_adv
		localparam crc32c_pkg::crc_mat_t AdvM = crc32c_pkg::adv_mat(k);
		assign prod[k] = crc32c_pkg::mat_mul(AdvM, crc32c_pkg::crc_t'(lane_byte));
	end

	always_comb begin
		contrib = '0;
		for (int k = 1; k <= MaxK; k++) begin
			if (count == crc32c_pkg::CmpW'(LANE + k)) begin
				contrib = prod[k];
			end
		end
	end

endmodule

/* src/crc32c_fold.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crc32c_fold: running remainder update
// advances the remainder (or the inverted seed) over count bytes and adds
// the merged byte contributions
// ---------------------------------------------------------------------------
module crc32c_fold #(
	parameter int BYTES = crc32c_pkg::BytesPerItemDef
) (
	input  crc32c_pkg::crc_t     rem,
	input  crc32c_pkg::item_s1_t item,
	output crc32c_pkg::crc_t     rem_next
);

	crc32c_pkg::crc_t base;
	crc32c_pkg::crc_t adv [0:BYTES];
	crc32c_pkg::crc_t adv_sel;

	assign base = item.start ? ~item.seed : rem;

	for (genvar k = 0; k <= BYTES; k++) begin : g_adv
		localparam crc32c_pkg::crc_mat_t AdvM = crc32c_pkg::adv_mat(k);
		assign adv[k] = crc32c_pkg::mat_mul(AdvM, base);
	end

	always_comb begin
		adv_sel = base;
		for (int k = 1; k <= BYTES; k++) begin
			if (item.count == crc32c_pkg::CmpW'(k)) begin
				adv_sel = adv[k];
			end
		end
	end

	assign rem_next = adv_sel ^ item.data_part;

endmodule

/* src/crc32c_stream_8byte.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crc32c_stream_8byte: streaming crc-32c checksum, up to eight bytes a word
// reflected castagnoli polynomial, byte 0 first, lsb first within a byte
// ---------------------------------------------------------------------------
//
//  channel | dir | fields (lowest bit up)                      | words
//  --------+-----+---------------------------------------------+--------------
//  s_*     | in  | tdata: message_bytes, byte_count, seed, pad | one per item
//          |     | tuser: start_req                            |
//  m_*     | out | tdata: checksum                             | one per input
//
//  one word in per cycle and one checksum out per cycle while m_tready is high;
//  m_tvalid rises once its word has passed the lane stage register into the
//  output register, a path held back only by m_tready
//  the rate is set by the remainder update in the fold unit, a fixed-depth
//  xor network on the remainder register; byte lanes sit in a stage ahead of it
//  reset: remainder all ones (checksum of an empty message is 0), no words
//  held; a stall on m_tready stops the output register, and the lane stage
//  keeps taking one more word until it fills as well
//
module crc32c_stream_8byte #(
	parameter int BYTES_PER_ITEM = crc32c_pkg::BytesPerItemDef
) (
	input  logic                               clk,
	input  logic                               arst_n,

	input  logic                               s_tvalid,
	output logic                               s_tready,
	// message_bytes [63:0], byte_count [67:64], seed [99:68], zero pad [103:100]
	input  logic [crc32c_pkg::InTdataW-1:0]    s_tdata,
	// start_req [0]
	input  logic [0:0]                         s_tuser,

	output logic                               m_tvalid,
	input  logic                               m_tready,
	// checksum [31:0]
	output logic [crc32c_pkg::OutTdataW-1:0]   m_tdata
);

	localparam int CmpW = crc32c_pkg::CmpW;

	// input field split
	logic [crc32c_pkg::DataW-1:0]  msg;
	logic [crc32c_pkg::CountW-1:0] count_in;
	logic [CmpW-1:0]               count_x;
	logic [CmpW-1:0]               count_sat;
	crc32c_pkg::crc_t              seed_in;

	// lane stage
	crc32c_pkg::crc_t              lane_contrib [BYTES_PER_ITEM];
	crc32c_pkg::crc_t              data_part;
	crc32c_pkg::item_s1_t          item_d;
	crc32c_pkg::item_s1_t          item_s1;
	logic                          valid_s1;

	// state and output
	crc32c_pkg::crc_t              rem_q;
	crc32c_pkg::crc_t              rem_next;
	logic                          out_valid_q;
	crc32c_pkg::crc_t              out_data_q;

	logic                          s_acc;
	logic                          s1_go;

	assign msg      = s_tdata[crc32c_pkg::MsgLsb   +: crc32c_pkg::DataW];
	assign count_in = s_tdata[crc32c_pkg::CountLsb +: crc32c_pkg::CountW];
	assign seed_in  = s_tdata[crc32c_pkg::SeedLsb  +: crc32c_pkg::CrcW];

	// counts above the lane count clamp to a full word
	assign count_x   = {1'b0, count_in};
	assign count_sat = (count_x > CmpW'(BYTES_PER_ITEM)) ? CmpW'(BYTES_PER_ITEM) : count_x;

	// one lane per byte position; positions past the data field fold zeros
	for (genvar i = 0; i < BYTES_PER_ITEM; i++) begin : g_lane
		logic [crc32c_pkg::ByteW-1:0] lane_byte;
		if (i < crc32c_pkg::DataBytes) begin : g_data
			assign lane_byte = msg[crc32c_pkg::ByteW*i +: crc32c_pkg::ByteW];
		end else begin : g_zero
			assign lane_byte = '0;
		end
		crc32c_lane #(
			.LANE  (i),
			.BYTES (BYTES_PER_ITEM)
		) u_lane (
			.lane_byte (lane_byte),
			.count     (count_sat),
			.contrib   (lane_contrib[i])
		);
	end

	// merge: lane results are linear, so they combine by xor
	always_comb begin
		data_part = '0;
		for (int i = 0; i < BYTES_PER_ITEM; i++) begin
			data_part = data_part ^ lane_contrib[i];
		end
	end

	assign item_d.data_part = data_part;
	assign item_d.seed      = seed_in;
	assign item_d.count     = count_sat;
	assign item_d.start     = s_tuser[0];

	// handshake: the lane stage moves on whenever the output register frees up
	assign s1_go    = valid_s1 & (~out_valid_q | m_tready);
	assign s_tready = ~valid_s1 | s1_go;
	assign s_acc    = s_tvalid & s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			item_s1 <= item_d;
		end
	end

	crc32c_fold #(
		.BYTES (BYTES_PER_ITEM)
	) u_fold (
		.rem      (rem_q),
		.item     (item_s1),
		.rem_next (rem_next)
	);

	// running remainder advances once per word leaving the lane stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q       <= '1;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_go) begin
				rem_q <= rem_next;
			end
			if (s1_go) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// finished checksum is the inverted remainder
	always_ff @(posedge clk) begin
		if (s1_go) begin
			out_data_q <= ~rem_next;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

/* src/crc32c_stream_8byte_chk.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crc32c_stream_8byte_chk: port-level checks for the checksum stream
// watches only the top-level ports and is bound to every instance
// ---------------------------------------------------------------------------
module crc32c_stream_8byte_chk (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic [crc32c_pkg::InTdataW-1:0]  s_tdata,
	input logic [0:0]                       s_tuser,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [crc32c_pkg::OutTdataW-1:0] m_tdata
);

	logic s_acc;
	logic seed_only;

	assign s_acc     = s_tvalid & s_tready;
	// start with no bytes: the checksum is the seed itself
	assign seed_only = s_acc & s_tuser[0] &
		(s_tdata[crc32c_pkg::CountLsb +: crc32c_pkg::CountW] == '0);

	// no result words while in reset, from the edge after reset is seen
	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !m_tvalid)
		else $error("result word shown during reset");

	// a held result word keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result word changed");

	// an open output side never blocks the input side
	a_no_block: assert property (@(posedge clk) m_tready |-> s_tready)
		else $error("input stalled while output is taken");

	// a taken word passes the lane stage into the output register when m_tready is high in between
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc ##1 m_tready |=> m_tvalid)
		else $error("result word missing after accepted word");

	// a restart with no bytes returns the seed
	a_seed_echo: assert property (@(posedge clk) disable iff (!arst_n)
		seed_only ##1 m_tready |=>
		m_tdata == $past(s_tdata[crc32c_pkg::SeedLsb +: crc32c_pkg::CrcW], 2))
		else $error("empty restart did not return the seed");

endmodule

bind crc32c_stream_8byte crc32c_stream_8byte_chk u_chk (.*);

/* sim/tb_crc32c_stream_8byte.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_crc32c_stream_8byte: self-checking bench for the crc-32c stream block
// drives eight-byte message words with byte counts, start flags and seeds,
// keeps its own bitwise crc-32c remainder and checks every checksum word in
// order, under phases of no idling, sender gaps, receiver stalls and both
// ---------------------------------------------------------------------------
module tb_crc32c_stream_8byte;

	localparam int BytesPerItem = crc32c_pkg::BytesPerItemDef;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;

	logic                              s_tvalid = 1'b0;
	logic                              s_tready;
	// message_bytes [63:0], byte_count [67:64], seed [99:68], zero pad [103:100]
	logic [crc32c_pkg::InTdataW-1:0]   s_tdata = '0;
	// start_req [0]
	logic [0:0]                        s_tuser = '0;

	logic                              m_tvalid;
	logic                              m_tready = 1'b0;
	// checksum [31:0]
	logic [crc32c_pkg::OutTdataW-1:0]  m_tdata;

	// bench-side copy of the running remainder and the checksums still owed
	crc32c_pkg::crc_t      model_rem;
	crc32c_pkg::crc_t      pending_sums[$];

	bit                    sender_idle;
	bit                    receiver_stall;
	int unsigned           stall_pct = 68;
	int unsigned           words_sent;
	int unsigned           sums_checked;
	int unsigned           start_words;
	int unsigned           oversize_words;
	int unsigned           errors;

	crc32c_stream_8byte u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #1 clk = ~clk;

	// fold the first n bytes of a word into a remainder, byte 0 first, lsb first
	function automatic crc32c_pkg::crc_t crc_fold_word(input crc32c_pkg::crc_t r,
			input logic [63:0] msg, input logic [3:0] cnt);
		crc32c_pkg::crc_t acc;
		logic [7:0]       b;
		int               n;
		acc = r;
		n = (cnt > BytesPerItem) ? BytesPerItem : int'(cnt);
		for (int i = 0; i < n; i++) begin
			b = (i < 8) ? msg[8*i +: 8] : 8'h00;
			acc = acc ^ {24'h0, b};
			for (int k = 0; k < 8; k++) begin
				acc = acc[0] ? ((acc >> 1) ^ crc32c_pkg::Poly) : (acc >> 1);
			end
		end
		return acc;
	endfunction

	// receiver side: ready high, or dropped stall_pct times in a hundred when stalling
	always @(posedge clk) begin
		if (receiver_stall) begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// checksum checker: every taken word is matched against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_sums.size() == 0) begin
				$error("checksum word 0x%08h with nothing expected", m_tdata);
				errors++;
			end else begin
				if (m_tdata !== pending_sums[0]) begin
					$error("checksum: expected 0x%08h, actual 0x%08h",
						pending_sums[0], m_tdata);
					errors++;
				end
				void'(pending_sums.pop_front());
			end
			sums_checked++;
		end
	end

	// send one word, with random gaps ahead of it when the sender idles
	task automatic send_word(input logic [63:0] msg, input logic [3:0] cnt,
			input bit start, input crc32c_pkg::crc_t seed);
		while (sender_idle && ($urandom_range(99) < 68)) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'h0, seed, cnt, msg};
		s_tuser  <= start;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		// taken at this edge: advance the model and queue the checksum
		if (start) begin
			model_rem = ~seed;
			start_words++;
		end
		if (cnt > BytesPerItem) begin
			oversize_words++;
		end
		model_rem = crc_fold_word(model_rem, msg, cnt);
		pending_sums.push_back(~model_rem);
		words_sent++;
	endtask

	function automatic logic [63:0] rand_msg();
		return {$urandom, $urandom};
	endfunction

	// empty message right after reset gives a zero checksum
	task automatic test_after_reset();
		send_word(64'h0, 4'd0, 1'b0, 32'h0);
		send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b0, 32'hFFFF_FFFF);
	endtask

	// standard check string "123456789" split over two words
	task automatic test_check_string();
		send_word(64'h3837_3635_3433_3231, 4'd8, 1'b1, 32'h0);
		send_word(64'h0000_0000_0000_0039, 4'd1, 1'b0, 32'h0);
		if (~model_rem !== 32'hE306_9283) begin
			$error("check string: expected 0x%08h, actual 0x%08h", 32'hE306_9283, ~model_rem);
			errors++;
		end
	endtask

	// all-zero and all-one data and seeds, full words
	task automatic test_field_extremes();
		send_word(64'h0, 4'd8, 1'b1, 32'h0);
		send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0, 32'h0);
		send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1, 32'hFFFF_FFFF);
		send_word(64'h0, 4'd8, 1'b1, 32'hFFFF_FFFF);
		send_word(64'h8000_0000_0000_0001, 4'd8, 1'b0, 32'h0);
	endtask

	// every count from one to eight, then counts past the word that saturate
	task automatic test_byte_counts();
		send_word(rand_msg(), 4'd1, 1'b1, 32'h0);
		for (int c = 2; c <= 8; c++) begin
			send_word(rand_msg(), 4'(c), 1'b0, $urandom);
		end
		send_word(rand_msg(), 4'd9, 1'b0, 32'h0);
		send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b0, 32'h0);
	endtask

	// zero count with start returns the seed; a seed without start is ignored
	task automatic test_seed_handling();
		send_word(rand_msg(), 4'd0, 1'b1, 32'hDEAD_BEEF);
		send_word(rand_msg(), 4'd0, 1'b1, 32'hFFFF_FFFF);
		send_word(rand_msg(), 4'd4, 1'b0, 32'h1234_5678);
		send_word(rand_msg(), 4'd0, 1'b0, 32'hFFFF_FFFF);
	endtask

	// random traffic: mostly whole messages, some stray and oversize words
	task automatic test_stream(input bit tx_idle, input bit rx_stall, input int n_words);
		int                sent;
		int                len;
		int                pick;
		crc32c_pkg::crc_t  seed;
		logic [3:0]        cnt;
		sent = 0;
		sender_idle = tx_idle;
		receiver_stall = rx_stall;
		while (sent < n_words) begin
			if ($urandom_range(9) < 8) begin
				len = $urandom_range(1, 10);
				pick = $urandom_range(2);
				// fresh start, extend the checksum so far, or any seed
				seed = (pick == 0) ? 32'h0 : (pick == 1) ? ~model_rem :
					crc32c_pkg::crc_t'($urandom);
				for (int k = 0; k < len; k++) begin
					if (k == len - 1 || $urandom_range(7) == 0) begin
						cnt = 4'($urandom_range(0, 8));
					end else begin
						cnt = 4'd8;
					end
					send_word(rand_msg(), cnt, k == 0,
						(k == 0) ? seed : crc32c_pkg::crc_t'($urandom));
				end
				sent += len;
			end else begin
				cnt = 4'($urandom_range(0, 15));
				send_word(rand_msg(), cnt, 1'($urandom_range(1)),
					crc32c_pkg::crc_t'($urandom));
				sent++;
			end
		end
	endtask

	initial begin
		model_rem = '1;
		sender_idle = 1'b0;
		receiver_stall = 1'b0;
		words_sent = 0;
		sums_checked = 0;
		start_words = 0;
		oversize_words = 0;
		errors = 0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_after_reset();
		test_check_string();
		test_field_extremes();
		test_byte_counts();
		test_seed_handling();

		test_stream(1'b0, 1'b0, 150);
		test_stream(1'b1, 1'b0, 150);
		test_stream(1'b0, 1'b1, 150);
		sender_idle = 1'b0;
		receiver_stall = 1'b0;
		test_stream(1'b0, 1'b0, 20);
		// both sides idle 23 times in a hundred: sender gaps drawn here
		stall_pct = 23;
		receiver_stall = 1'b1;
		begin
			int n;
			n = 0;
			while (n < 150) begin
				if ($urandom_range(99) < 23) begin
					s_tvalid <= 1'b0;
					@(posedge clk);
				end else begin
					send_word(rand_msg(), 4'($urandom_range(0, 15)),
						1'($urandom_range(3) == 0), crc32c_pkg::crc_t'($urandom));
					n++;
				end
			end
		end

		s_tvalid <= 1'b0;
		receiver_stall = 1'b0;
		while (pending_sums.size() != 0) begin
			@(posedge clk);
		end
		// let a stray word still in the pipeline show before the summary
		repeat (10) @(posedge clk);

		$display("sent %0d words (%0d starts, %0d oversize counts), checked %0d checksums",
			words_sent, start_words, oversize_words, sums_checked);
		$display("phases: directed, free-running, sender gaps, receiver stalls, both");
		if (errors == 0 && pending_sums.size() == 0) begin
			$display("tb_crc32c_stream_8byte: done, clean");
		end else begin
			$display("tb_crc32c_stream_8byte: done, errors");
		end
		$finish;
	end

	// hang guard, far beyond the slowest expected run
	initial begin
		#400000;
		$display("timeout with %0d checksums still expected", pending_sums.size());
		$display("tb_crc32c_stream_8byte: done, errors");
		$finish;
	end

endmodule
